FILE: sv/pmft_pkg.sv
// Shared types and constants for the prefix-minimum Fenwick tree unit.
// Used by pmft_ctrl, pmft_datapath and prefix_min_fenwick_tree_unit.
package pmft_pkg;

   localparam int unsigned POS_W = 11;   // position / size width
   localparam int unsigned VAL_W = 30;   // stored minimum width
   localparam int unsigned IDX_W = 12;   // tree walk index (climb may pass 2047)

   localparam logic [VAL_W-1:0] INFINITE_MIN = 30'd1000000000;
   localparam logic [POS_W-1:0] SIZE_RESET   = 11'd1024;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture an accepted item
      logic step;      // read one tree node and advance the index
      logic clear;     // write infinity at the clear pointer
      logic rsp_load;  // move the finished minimum into the output register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_done;   // no node left to visit
      logic clear_last;  // clear pointer at the last entry
      logic is_query;    // item in flight is a query
   } dp_status_type;

endpackage

FILE: sv/pmft_ctrl.sv
// Controller state machine for the prefix-minimum Fenwick tree unit.
// Depends on pmft_pkg (state, command and status types).
module pmft_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  pmft_pkg::dp_status_type st,
   output pmft_pkg::ctl_cmd_type   cmd
);

   pmft_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmft_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pmft_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) begin
               state_in = pmft_pkg::ST_IDLE;
            end
         end
         pmft_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = pmft_pkg::ST_WALK;
            end
         end
         pmft_pkg::ST_WALK: begin
            if (st.walk_done) begin
               state_in = st.is_query ? pmft_pkg::ST_DONE : pmft_pkg::ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         pmft_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = pmft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmft_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: sv/pmft_datapath.sv
// Datapath of the prefix-minimum Fenwick tree unit: node memory, walk index,
// size register, min compare and output register. Depends on pmft_pkg.
module pmft_datapath #(
   parameter int unsigned ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pmft_pkg::ctl_cmd_type          cmd,
   output pmft_pkg::dp_status_type        st,
   input  logic                          item_kind,
   input  logic [pmft_pkg::POS_W-1:0]    item_position,
   input  logic [pmft_pkg::VAL_W-1:0]    item_value,
   input  logic                          csr_write,
   input  logic [pmft_pkg::POS_W-1:0]    csr_size,
   output logic [pmft_pkg::VAL_W-1:0]    prefix_min
);

   localparam int unsigned AW  = $clog2(ENTRIES);
   localparam int unsigned CAP = (ENTRIES < 2047) ? ENTRIES : 2047;

   logic [pmft_pkg::VAL_W-1:0] mem [ENTRIES];

   logic [pmft_pkg::POS_W-1:0] size_ff;
   logic [pmft_pkg::POS_W-1:0] lim_ff, lim_in;
   logic [pmft_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [pmft_pkg::VAL_W-1:0] val_ff;
   logic                       kind_ff;
   logic [pmft_pkg::VAL_W-1:0] best_ff, best_in;
   logic [pmft_pkg::VAL_W-1:0] rd_data_ff;
   logic [AW-1:0]              pend_addr_ff;
   logic                       pend_ff;
   logic [AW-1:0]              clr_ff;
   logic [pmft_pkg::VAL_W-1:0] out_ff;

   logic [pmft_pkg::IDX_W-1:0] low_bit;
   logic [pmft_pkg::IDX_W-1:0] pos_ext;
   logic [AW-1:0]              rd_addr;
   logic                       upd_we;
   logic                       we;
   logic [AW-1:0]              wr_addr;
   logic [pmft_pkg::VAL_W-1:0] wr_data;

   // size in use, clamped to the memory depth
   assign lim_in  = (size_ff > pmft_pkg::POS_W'(CAP)) ? pmft_pkg::POS_W'(CAP) : size_ff;
   assign pos_ext = pmft_pkg::IDX_W'(item_position);
   assign low_bit = idx_ff & (~idx_ff + pmft_pkg::IDX_W'(1));
   assign rd_addr = AW'(idx_ff - pmft_pkg::IDX_W'(1));

   always_comb begin
      if (cmd.load) begin
         if (item_kind == pmft_pkg::CMD_QUERY) begin
            idx_in = (item_position > lim_in) ? pmft_pkg::IDX_W'(lim_in) : pos_ext;
         end else begin
            idx_in = pos_ext + pmft_pkg::IDX_W'(1);
         end
      end else if (cmd.step) begin
         idx_in = (kind_ff == pmft_pkg::CMD_QUERY) ? idx_ff - low_bit : idx_ff + low_bit;
      end else begin
         idx_in = idx_ff;
      end
   end

   assign st.is_query   = (kind_ff == pmft_pkg::CMD_QUERY);
   assign st.walk_done  = st.is_query ? (idx_ff == '0)
                                      : (idx_ff > pmft_pkg::IDX_W'(lim_ff));
   assign st.clear_last = (clr_ff == AW'(ENTRIES - 1));

   // node read registered in the previous cycle is resolved here
   assign upd_we = pend_ff && !st.is_query && (val_ff < rd_data_ff);

   always_comb begin
      if (cmd.load) begin
         best_in = pmft_pkg::INFINITE_MIN;
      end else if (pend_ff && st.is_query && (rd_data_ff < best_ff)) begin
         best_in = rd_data_ff;
      end else begin
         best_in = best_ff;
      end
   end

   assign we      = cmd.clear || upd_we;
   assign wr_addr = cmd.clear ? clr_ff : pend_addr_ff;
   assign wr_data = cmd.clear ? pmft_pkg::INFINITE_MIN : val_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= pmft_pkg::SIZE_RESET;
         pend_ff <= 1'b0;
         clr_ff  <= '0;
         idx_ff  <= '0;
         kind_ff <= pmft_pkg::CMD_UPDATE;
      end else begin
         if (csr_write) begin
            size_ff <= csr_size;
         end
         pend_ff <= cmd.step;
         if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         idx_ff <= idx_in;
         if (cmd.load) begin
            kind_ff <= item_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lim_ff <= lim_in;
         val_ff <= item_value;
      end
      if (cmd.step) begin
         pend_addr_ff <= rd_addr;
      end
      best_ff <= best_in;
      if (cmd.rsp_load) begin
         out_ff <= best_ff;
      end
   end

   assign prefix_min = out_ff;

endmodule

FILE: sv/prefix_min_fenwick_tree_unit.sv
// Top level of the prefix-minimum Fenwick tree unit.
// Depends on pmft_pkg, pmft_ctrl and pmft_datapath.
//
// Usage:
//  - req_* carries one command per beat. tuser = 0 lowers the minimum at a
//    zero-based position to value; tuser = 1 asks for the minimum over the
//    first "position" positions. Updates return nothing; each query returns
//    one rsp_* beat with the minimum, 1000000000 when nothing is stored.
//  - csr_* writes size_in_use (positions in use, clamped to ENTRIES). Write
//    it only while no command is in flight.
//  - Tree nodes are visited one per cycle through the single node memory
//    (read, then compare-and-write in the next cycle, overlapped with the next
//    read). An update climbs at most floor(log2(size))+1 nodes (11 at size
//    1024), a query at most floor(log2(size+1)) nodes (10 at size 1024).
//  - An update occupies the block while it walks its nodes; a query also
//    waits in ST_DONE for the output register. rsp_tvalid rises when the
//    finished minimum is loaded into the output register, once that
//    register is free.
//  - After reset the node memory is swept to infinity, one entry per cycle,
//    over all ENTRIES entries; req_tready stays low during the sweep.
//    size_in_use resets to 1024.
//  - rsp_* is held in an output register: a stalled receiver does not keep
//    new commands out; only a second query waits until the held beat leaves.
module prefix_min_fenwick_tree_unit #(
   parameter int unsigned ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [10:0] position, [40:11] value, [47:41] zero
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [29:0] prefix_min, [31:30] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_wdata    // [10:0] size_in_use
);

   pmft_pkg::ctl_cmd_type        cmd;
   pmft_pkg::dp_status_type      st;
   logic [pmft_pkg::VAL_W-1:0]   prefix_min;

   // register is always writable
   assign csr_ready = 1'b1;

   pmft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   pmft_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .item_kind     (req_tuser[0]),
      .item_position (req_tdata[10:0]),
      .item_value    (req_tdata[40:11]),
      .csr_write     (csr_valid && csr_ready),
      .csr_size      (csr_wdata),
      .prefix_min    (prefix_min)
   );

   assign rsp_tdata = {2'b00, prefix_min};

endmodule
